@@ design/tewt_pkg.sv @@
// Shared constants, codes and transaction types of the timeline cue window tracker.
package tewt_pkg;

    localparam int MAX_CUES     = 16;
    localparam int TIME_W       = 32;
    localparam int KIND_W       = 8;
    localparam int PAYLOAD_W    = 32;
    localparam int MODE_W       = 2;
    localparam int REP_W        = 2;
    localparam int ENTRY_IDX_W  = 4;
    localparam int CFG_COUNT_W  = 5;
    localparam int IDX_W        = $clog2(MAX_CUES);
    localparam int CNT_W        = $clog2(MAX_CUES + 1);
    localparam int SUM_W        = TIME_W + 1;
    localparam int DIVCNT_W     = $clog2(SUM_W + 1);
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    // Transaction modes
    localparam logic [MODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] OP_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] OP_SET   = 2'd2;
    localparam logic [MODE_W-1:0] OP_RESET = 2'd3;

    // Result report codes
    localparam logic [REP_W-1:0] REP_ACT    = 2'd0;
    localparam logic [REP_W-1:0] REP_DEACT  = 2'd1;
    localparam logic [REP_W-1:0] REP_STATUS = 2'd2;

    // Register indexes (word address)
    localparam logic [1:0] REG_DURATION = 2'd0;
    localparam logic [1:0] REG_LOOP     = 2'd1;
    localparam logic [1:0] REG_COUNT    = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]    op;
        logic [TIME_W-1:0]    tval;
        logic [IDX_W-1:0]     idx;
        logic                 wr_ok;
        logic [TIME_W-1:0]    cue_start;
        logic [TIME_W-1:0]    cue_end;
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
    } t_cmd;

    typedef struct packed {
        logic              go;
        logic [SUM_W-1:0]  dividend;
        logic [TIME_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] rem;
    } t_mod_rsp;

endpackage

@@ design/tewt_front.sv @@
// Front end: accepts transactions and classifies them into queue commands.
module tewt_front (
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [tewt_pkg::MODE_W-1:0]        i_mode,
    input  logic [tewt_pkg::TIME_W-1:0]        i_time_value,
    input  logic [tewt_pkg::ENTRY_IDX_W-1:0]   i_entry_index,
    input  logic [tewt_pkg::TIME_W-1:0]        i_entry_start,
    input  logic [tewt_pkg::TIME_W-1:0]        i_entry_end,
    input  logic [tewt_pkg::KIND_W-1:0]        i_entry_kind,
    input  logic [tewt_pkg::PAYLOAD_W-1:0]     i_entry_payload,
    input  logic [tewt_pkg::TIME_W-1:0]        i_duration,
    output logic                               o_push,
    output tewt_pkg::t_cmd                     o_cmd
);
    import tewt_pkg::*;

    assign o_push = i_start & ~i_busy;

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = i_mode;
        o_cmd.tval      = i_time_value;
        o_cmd.idx       = IDX_W'(i_entry_index);
        o_cmd.cue_start = i_entry_start;
        o_cmd.cue_end   = i_entry_end;
        o_cmd.kind      = i_entry_kind;
        o_cmd.payload   = i_entry_payload;
        unique case (i_mode)
            OP_TICK: begin
                o_cmd.wr_ok = 1'b0;
            end
            OP_WRITE: begin
                // drop writes to slots beyond the table
                o_cmd.wr_ok = (32'(i_entry_index) < 32'(MAX_CUES));
            end
            OP_SET: begin
                // clamp the new time at the clip duration
                o_cmd.wr_ok = 1'b0;
                if (i_time_value > i_duration) begin
                    o_cmd.tval = i_duration;
                end
            end
            OP_RESET: begin
                o_cmd.wr_ok = 1'b0;
            end
            default: begin
                o_cmd.wr_ok = 1'b0;
            end
        endcase
    end

endmodule

@@ design/tewt_fifo.sv @@
// Short command queue between the front end and the execution engine.
module tewt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tewt_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output tewt_pkg::t_cmd o_head,
    output logic           o_full,
    output logic           o_empty
);
    import tewt_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (32'(r_wptr) == QDEPTH - 1) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (32'(r_rptr) == QDEPTH - 1) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/tewt_mod.sv @@
// Serial restoring remainder unit: one dividend bit per cycle.
module tewt_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tewt_pkg::t_mod_req i_req,
    output tewt_pkg::t_mod_rsp o_rsp
);
    import tewt_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DIVCNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]   r_rem;
    logic [SUM_W-1:0]    r_dvd;
    logic [TIME_W-1:0]   r_div;
    logic [SUM_W-1:0]    w_trial;
    logic [SUM_W-1:0]    w_div_ext;
    logic                w_fits;

    assign w_trial   = {r_rem, r_dvd[SUM_W-1]};
    assign w_div_ext = {1'b0, r_div};
    assign w_fits    = (w_trial >= w_div_ext);

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            if (w_fits) begin
                r_rem <= TIME_W'(w_trial - w_div_ext);
            end else begin
                r_rem <= w_trial[TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= DIVCNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIVCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ design/tewt_back.sv @@
// Execution engine: time update, cue table, cue walk and result register.
module tewt_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  tewt_pkg::t_cmd                    i_cmd,
    output logic                              o_pop,
    input  logic [tewt_pkg::TIME_W-1:0]       i_duration,
    input  logic                              i_loop,
    input  logic [tewt_pkg::CFG_COUNT_W-1:0]  i_cue_count,
    output tewt_pkg::t_mod_req                o_mod_req,
    input  tewt_pkg::t_mod_rsp                i_mod_rsp,
    output logic                              o_result_valid,
    output logic [tewt_pkg::REP_W-1:0]        o_report,
    output logic [tewt_pkg::ENTRY_IDX_W-1:0]  o_cue_index,
    output logic [tewt_pkg::KIND_W-1:0]       o_cue_kind,
    output logic [tewt_pkg::PAYLOAD_W-1:0]    o_cue_payload,
    output logic [tewt_pkg::TIME_W-1:0]       o_play_time,
    output logic                              o_finished,
    output logic                              o_last
);
    import tewt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUM    = 3'd1;
    localparam logic [2:0] S_DEC    = 3'd2;
    localparam logic [2:0] S_MOD    = 3'd3;
    localparam logic [2:0] S_DEACT  = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_STATUS = 3'd6;

    // cue table, no reset
    logic [TIME_W-1:0]    r_start   [MAX_CUES];
    logic [TIME_W-1:0]    r_end     [MAX_CUES];
    logic [KIND_W-1:0]    r_kind    [MAX_CUES];
    logic [PAYLOAD_W-1:0] r_payload [MAX_CUES];

    logic [2:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_second, n_second;
    logic                 r_after_scan, n_after_scan;
    logic [TIME_W-1:0]    r_time, n_time;
    logic [TIME_W-1:0]    r_prev, n_prev;
    logic [TIME_W-1:0]    r_dt, n_dt;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [MAX_CUES-1:0]  r_marks, n_marks;

    logic                 r_out_valid;
    logic [REP_W-1:0]     r_out_report;
    logic [ENTRY_IDX_W-1:0] r_out_index;
    logic [KIND_W-1:0]    r_out_kind;
    logic [PAYLOAD_W-1:0] r_out_payload;
    logic [TIME_W-1:0]    r_out_time;
    logic                 r_out_finished;
    logic                 r_out_last;

    logic [CNT_W-1:0]     w_cnt;
    logic [IDX_W-1:0]     w_slot;
    logic                 w_in_range;
    logic [TIME_W-1:0]    w_s;
    logic [TIME_W-1:0]    w_e;
    logic                 w_mark;
    logic                 w_oneshot;
    logic                 w_should;
    logic                 w_cross;
    logic                 w_tbl_we;
    logic                 w_mod_go;
    logic                 w_emit;
    logic [REP_W-1:0]     w_emit_rep;
    logic                 w_status;

    assign w_cnt      = (32'(i_cue_count) > 32'(MAX_CUES)) ? CNT_W'(MAX_CUES)
                                                            : CNT_W'(i_cue_count);
    assign w_slot     = r_idx[IDX_W-1:0];
    assign w_in_range = (r_idx < w_cnt);
    assign w_s        = r_start[w_slot];
    assign w_e        = r_end[w_slot];
    assign w_mark     = r_marks[w_slot];
    assign w_oneshot  = (w_s == w_e);
    assign w_should   = (r_time >= w_s) && (r_time < w_e);
    assign w_cross    = (r_prev <= w_s) && (r_time > w_s);
    assign w_status   = w_emit && (w_emit_rep == REP_STATUS);

    assign o_mod_req.go       = w_mod_go;
    assign o_mod_req.dividend = r_sum;
    assign o_mod_req.divisor  = i_duration;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_second     = r_second;
        n_after_scan = r_after_scan;
        n_time       = r_time;
        n_prev       = r_prev;
        n_dt         = r_dt;
        n_sum        = r_sum;
        n_marks      = r_marks;
        o_pop        = 1'b0;
        w_tbl_we     = 1'b0;
        w_mod_go     = 1'b0;
        w_emit       = 1'b0;
        w_emit_rep   = REP_STATUS;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_TICK: begin
                            n_dt    = i_cmd.tval;
                            n_state = S_SUM;
                        end
                        OP_WRITE: begin
                            w_tbl_we = i_cmd.wr_ok;
                            n_state  = S_STATUS;
                        end
                        OP_SET: begin
                            n_time  = i_cmd.tval;
                            n_marks = '0;
                            n_state = S_STATUS;
                        end
                        OP_RESET: begin
                            n_time       = '0;
                            n_idx        = '0;
                            n_after_scan = 1'b0;
                            n_state      = S_DEACT;
                        end
                        default: begin
                            n_state = S_STATUS;
                        end
                    endcase
                end
            end
            S_SUM: begin
                n_sum   = {1'b0, r_time} + {1'b0, r_dt};
                n_state = S_DEC;
            end
            S_DEC: begin
                n_idx    = '0;
                n_second = 1'b0;
                if (r_sum >= {1'b0, i_duration}) begin
                    if (i_loop) begin
                        n_prev       = '0;
                        n_after_scan = 1'b1;
                        if (i_duration == '0) begin
                            n_time  = '0;
                            n_state = S_DEACT;
                        end else begin
                            w_mod_go = 1'b1;
                            n_state  = S_MOD;
                        end
                    end else begin
                        n_prev  = r_time;
                        n_time  = i_duration;
                        n_state = S_SCAN;
                    end
                end else begin
                    n_prev  = r_time;
                    n_time  = r_sum[TIME_W-1:0];
                    n_state = S_SCAN;
                end
            end
            S_MOD: begin
                if (i_mod_rsp.done) begin
                    n_time  = i_mod_rsp.rem;
                    n_state = S_DEACT;
                end
            end
            S_DEACT: begin
                if (!w_in_range) begin
                    n_marks  = '0;
                    n_idx    = '0;
                    n_second = 1'b0;
                    n_state  = r_after_scan ? S_SCAN : S_STATUS;
                end else begin
                    if (w_mark && !w_oneshot) begin
                        w_emit     = 1'b1;
                        w_emit_rep = REP_DEACT;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN: begin
                if (!w_in_range) begin
                    n_state = S_STATUS;
                end else if (w_oneshot) begin
                    if (!w_mark && w_cross) begin
                        w_emit = 1'b1;
                        if (!r_second) begin
                            w_emit_rep = REP_ACT;
                            n_second   = 1'b1;
                        end else begin
                            w_emit_rep      = REP_DEACT;
                            n_second        = 1'b0;
                            n_marks[w_slot] = 1'b1;
                            n_idx           = r_idx + 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (!w_mark && w_should) begin
                        n_marks[w_slot] = 1'b1;
                        w_emit          = 1'b1;
                        w_emit_rep      = REP_ACT;
                    end else if (w_mark && !w_should) begin
                        n_marks[w_slot] = 1'b0;
                        w_emit          = 1'b1;
                        w_emit_rep      = REP_DEACT;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_STATUS: begin
                w_emit     = 1'b1;
                w_emit_rep = REP_STATUS;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_start[i_cmd.idx]   <= i_cmd.cue_start;
            r_end[i_cmd.idx]     <= i_cmd.cue_end;
            r_kind[i_cmd.idx]    <= i_cmd.kind;
            r_payload[i_cmd.idx] <= i_cmd.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_after_scan <= n_after_scan;
        r_prev       <= n_prev;
        r_dt         <= n_dt;
        r_sum        <= n_sum;
        if (w_emit) begin
            r_out_report   <= w_emit_rep;
            r_out_index    <= w_status ? '0 : ENTRY_IDX_W'(w_slot);
            r_out_kind     <= w_status ? '0 : r_kind[w_slot];
            r_out_payload  <= w_status ? '0 : r_payload[w_slot];
            r_out_time     <= r_time;
            r_out_finished <= !i_loop && (r_time >= i_duration);
            r_out_last     <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_marks     <= '0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_marks     <= n_marks;
            r_second    <= n_second;
            r_out_valid <= w_emit;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_report       = r_out_report;
    assign o_cue_index    = r_out_index;
    assign o_cue_kind     = r_out_kind;
    assign o_cue_payload  = r_out_payload;
    assign o_play_time    = r_out_time;
    assign o_finished     = r_out_finished;
    assign o_last         = r_out_last;

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |=> !r_out_valid)
        else $error("result directly after a status result");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_report == REP_STATUS)))
        else $error("last flag disagrees with report code");

    a_second_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_state == S_SCAN) && w_in_range && w_oneshot)
        else $error("one-shot second half outside a valid cue");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> !$past(o_pop))
        else $error("queue popped while a command is executing");

endmodule

@@ design/timeline_event_window_tracker.sv @@
// Top level of the timeline cue window tracker: register port, front end, queue, engine.
//
// Commands enter on start when busy is low; a two-entry queue sits between the front
// end and the engine, and busy rises only while that queue is full. Every command ends
// with exactly one status result (o_last high); cue results come first, one per cycle,
// each on the result ports for a single cycle marked by o_result_valid, and the
// receiver cannot stall them. All results of a command carry the final play time.
// A write or set-time command goes from the idle state straight to its status result. A
// tick adds the time step, decides whether the clip wraps and walks the cue table for
// activations and deactivations; a one-shot cue that fires gives two results from one
// entry. A looping tick that wraps first runs the serial remainder unit (33 dividend
// bits, one per cycle), then a deactivation walk, before the cue walk; a zero clip length
// skips the remainder unit. The reset command runs only the deactivation walk. An idle
// engine takes a command the cycle after it is accepted, and each result reaches the
// ports the cycle after the engine produces it. The walks cover cue_count entries, the
// number of cues scanned (at most 16), one entry per cycle, but a one-shot cue that
// fires holds the walk on that entry for its second result. Write the registers only
// while no command is pending or running.
module timeline_event_window_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command port
    input  logic                               start,
    output logic                               busy,
    input  logic [tewt_pkg::MODE_W-1:0]        i_mode,
    input  logic [tewt_pkg::TIME_W-1:0]        i_time_value,
    input  logic [tewt_pkg::ENTRY_IDX_W-1:0]   i_entry_index,
    input  logic [tewt_pkg::TIME_W-1:0]        i_entry_start,
    input  logic [tewt_pkg::TIME_W-1:0]        i_entry_end,
    input  logic [tewt_pkg::KIND_W-1:0]        i_entry_kind,
    input  logic [tewt_pkg::PAYLOAD_W-1:0]     i_entry_payload,
    // result port
    output logic                               o_result_valid,
    output logic [tewt_pkg::REP_W-1:0]         o_report,
    output logic [tewt_pkg::ENTRY_IDX_W-1:0]   o_cue_index,
    output logic [tewt_pkg::KIND_W-1:0]        o_cue_kind,
    output logic [tewt_pkg::PAYLOAD_W-1:0]     o_cue_payload,
    output logic [tewt_pkg::TIME_W-1:0]        o_play_time,
    output logic                               o_finished,
    output logic                               o_last,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tewt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tewt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tewt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import tewt_pkg::*;

    // configuration registers
    logic [TIME_W-1:0]      r_duration;
    logic                   r_loop;
    logic [CFG_COUNT_W-1:0] r_cue_count;

    logic       w_cfg_wr;
    logic [1:0] w_reg_sel;

    logic       w_push;
    t_cmd       w_cmd;
    t_cmd       w_head;
    logic       w_full;
    logic       w_empty;
    logic       w_pop;
    t_mod_req   w_mod_req;
    t_mod_rsp   w_mod_rsp;

    // Register port: zero wait states, word-addressed registers.
    assign pready    = 1'b1;
    assign w_reg_sel = paddr[3:2];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration  <= TIME_W'(65536);
            r_loop      <= 1'b1;
            r_cue_count <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_sel)
                REG_DURATION: r_duration  <= pwdata[TIME_W-1:0];
                REG_LOOP:     r_loop      <= pwdata[0];
                REG_COUNT:    r_cue_count <= pwdata[CFG_COUNT_W-1:0];
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_DURATION: prdata = APB_DATA_W'(r_duration);
            REG_LOOP:     prdata = APB_DATA_W'(r_loop);
            REG_COUNT:    prdata = APB_DATA_W'(r_cue_count);
            default:      prdata = '0;
        endcase
    end

    // Hold off new commands only while the queue is full.
    assign busy = w_full;

    tewt_front u_front (
        .i_start         (start),
        .i_busy          (w_full),
        .i_mode          (i_mode),
        .i_time_value    (i_time_value),
        .i_entry_index   (i_entry_index),
        .i_entry_start   (i_entry_start),
        .i_entry_end     (i_entry_end),
        .i_entry_kind    (i_entry_kind),
        .i_entry_payload (i_entry_payload),
        .i_duration      (r_duration),
        .o_push          (w_push),
        .o_cmd           (w_cmd)
    );

    tewt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tewt_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    tewt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_cmd          (w_head),
        .o_pop          (w_pop),
        .i_duration     (r_duration),
        .i_loop         (r_loop),
        .i_cue_count    (r_cue_count),
        .o_mod_req      (w_mod_req),
        .i_mod_rsp      (w_mod_rsp),
        .o_result_valid (o_result_valid),
        .o_report       (o_report),
        .o_cue_index    (o_cue_index),
        .o_cue_kind     (o_cue_kind),
        .o_cue_payload  (o_cue_payload),
        .o_play_time    (o_play_time),
        .o_finished     (o_finished),
        .o_last         (o_last)
    );

endmodule
